FILE: src/csc_pkg.sv
//------------------------------------------------------------------------------
// csc_pkg
// Shared constants and types for the capsule/sphere collision pipeline.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

   // Fraction bits of the projection parameter t
   localparam int T_BITS = 32;
   // Span above which the dot products are scaled down before the divide
   localparam int NORM_BITS = 96;

   // Where the closest point on the segment lies
   typedef enum logic [1:0] {
      MODE_TOP    = 2'd0,
      MODE_BOTTOM = 2'd1,
      MODE_MID    = 2'd2
   } mode_type;

   // Cycles from an accepted transfer to its result strobe
   function automatic int csc_latency(input int coord_width);
      return 14 + T_BITS + 2 * coord_width;
   endfunction

endpackage

`default_nettype wire

FILE: src/capsule_sphere_collision.sv
//------------------------------------------------------------------------------
// capsule_sphere_collision
// Capsule versus sphere overlap test with push-back vector, fixed point.
//------------------------------------------------------------------------------
// The block takes one query per clock and gives each result in order, as a
// one-cycle rsp_valid strobe. The pipeline holds the 32-step divide that finds
// the projection parameter, the bit-per-stage square root of the squared
// distance and the COORD_WIDTH-step divide of the push-back. busy is high only
// while reset is held. Results cannot be held off: a receiver must take each
// strobe as it comes.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module capsule_sphere_collision #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [COORD_WIDTH-1:0] req_top_x,
   input  wire logic [COORD_WIDTH-1:0] req_top_y,
   input  wire logic [COORD_WIDTH-1:0] req_top_z,
   input  wire logic [COORD_WIDTH-1:0] req_bottom_x,
   input  wire logic [COORD_WIDTH-1:0] req_bottom_y,
   input  wire logic [COORD_WIDTH-1:0] req_bottom_z,
   input  wire logic [COORD_WIDTH-2:0] req_capsule_radius,
   input  wire logic [COORD_WIDTH-1:0] req_center_x,
   input  wire logic [COORD_WIDTH-1:0] req_center_y,
   input  wire logic [COORD_WIDTH-1:0] req_center_z,
   input  wire logic [COORD_WIDTH-2:0] req_sphere_radius,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic [COORD_WIDTH-1:0]      rsp_push_x,
   output logic [COORD_WIDTH-1:0]      rsp_push_y,
   output logic [COORD_WIDTH-1:0]      rsp_push_z
);

   import csc_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int DW = 2 * W + 4;
   localparam int NW = (DW > NORM_BITS) ? NORM_BITS : DW;
   localparam int LW = W + 3;

   typedef struct packed {
      mode_type              mode;
      logic [2:0][W-1:0]     top;
      logic [2:0][W:0]       dir;
      logic [2:0][W-1:0]     cen;
      logic [W-1:0]          rsum;
   } seg_tag_type;

   typedef struct packed {
      logic [2:0][W+1:0]     v;
      logic [W-1:0]          rsum;
   } dist_tag_type;

   typedef struct packed {
      logic hit;
      logic zlen;
      logic vneg;
      logic ovf;
   } push_tag_type;

   assign busy = reset;

   // stage 1: capture the transfer
   logic              v1_ff;
   logic [2:0][W-1:0] top1_ff, bot1_ff, cen1_ff;
   logic [W-1:0]      rsum1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      top1_ff  <= {req_top_z, req_top_y, req_top_x};
      bot1_ff  <= {req_bottom_z, req_bottom_y, req_bottom_x};
      cen1_ff  <= {req_center_z, req_center_y, req_center_x};
      rsum1_ff <= W'(req_capsule_radius) + W'(req_sphere_radius);
   end

   // stage 2: per-axis products for p.d and d.d
   logic signed [W:0] a_c [3];
   logic signed [W:0] d_c [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_c[i] = {cen1_ff[i][W-1], cen1_ff[i]} - {top1_ff[i][W-1], top1_ff[i]};
         d_c[i] = {bot1_ff[i][W-1], bot1_ff[i]} - {top1_ff[i][W-1], top1_ff[i]};
      end
   end

   logic                   v2_ff;
   logic signed [2*W+1:0]  pnd2_ff [3];
   logic [2*W+1:0]         pdd2_ff [3];
   logic [2:0][W-1:0]      top2_ff, cen2_ff;
   logic [2:0][W:0]        dir2_ff;
   logic [W-1:0]           rsum2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pnd2_ff[i] <= a_c[i] * d_c[i];
         pdd2_ff[i] <= d_c[i] * d_c[i];
         dir2_ff[i] <= d_c[i];
      end
      top2_ff  <= top1_ff;
      cen2_ff  <= cen1_ff;
      rsum2_ff <= rsum1_ff;
   end

   // stage 3: sum the dot products
   logic                  v3_ff;
   logic signed [DW-1:0]  num3_ff;
   logic [DW-1:0]         den3_ff;
   logic [2:0][W-1:0]     top3_ff, cen3_ff;
   logic [2:0][W:0]       dir3_ff;
   logic [W-1:0]          rsum3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      num3_ff  <= DW'(pnd2_ff[0]) + DW'(pnd2_ff[1]) + DW'(pnd2_ff[2]);
      den3_ff  <= DW'(pdd2_ff[0]) + DW'(pdd2_ff[1]) + DW'(pdd2_ff[2]);
      top3_ff  <= top2_ff;
      dir3_ff  <= dir2_ff;
      cen3_ff  <= cen2_ff;
      rsum3_ff <= rsum2_ff;
   end

   // stage 4: clamp decision and scale-down of a wide denominator
   mode_type      mode_c;
   logic [7:0]    shamt_c;
   logic [NW-1:0] numn_c, denn_c;

   always_comb begin
      if (den3_ff == '0 || num3_ff[DW-1] || num3_ff == '0) begin
         mode_c = MODE_TOP;
      end else if ($unsigned(num3_ff) >= den3_ff) begin
         mode_c = MODE_BOTTOM;
      end else begin
         mode_c = MODE_MID;
      end
      shamt_c = '0;
      for (int k = NORM_BITS; k < DW; k++) begin
         if (den3_ff[k]) begin
            shamt_c = 8'(k - NORM_BITS + 1);
         end
      end
      numn_c = NW'($unsigned(num3_ff) >> shamt_c);
      denn_c = NW'(den3_ff >> shamt_c);
   end

   logic          v4_ff;
   logic [NW-1:0] rem4_ff, den4_ff;
   seg_tag_type   seg4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem4_ff      <= (mode_c == MODE_MID) ? numn_c : '0;
      den4_ff      <= denn_c;
      seg4_ff.mode <= mode_c;
      seg4_ff.top  <= top3_ff;
      seg4_ff.dir  <= dir3_ff;
      seg4_ff.cen  <= cen3_ff;
      seg4_ff.rsum <= rsum3_ff;
   end

   // projection parameter t = num * 2^32 / den
   logic               tdiv_valid;
   logic [T_BITS-1:0]  tdiv_quo;
   logic [$bits(seg_tag_type)-1:0] tdiv_tag;
   seg_tag_type        seg_q;

   csc_div #(
      .QW (T_BITS),
      .DW (NW),
      .TW ($bits(seg_tag_type))
   ) u_tdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_rem    (rem4_ff),
      .in_low    ('0),
      .in_den    (den4_ff),
      .in_tag    (seg4_ff),
      .out_valid (tdiv_valid),
      .out_quo   (tdiv_quo),
      .out_tag   (tdiv_tag)
   );

   assign seg_q = tdiv_tag;

   // stage 5: offset along the segment, |d| * t / 2^32
   logic [T_BITS:0]       t_c;
   logic [W:0]            magd_c [3];
   logic [W+T_BITS+1:0]   offp_c [3];

   always_comb begin
      case (seg_q.mode)
         MODE_BOTTOM: t_c = (T_BITS+1)'(1) << T_BITS;
         MODE_MID:    t_c = {1'b0, tdiv_quo};
         default:     t_c = '0;
      endcase
      for (int i = 0; i < 3; i++) begin
         magd_c[i] = seg_q.dir[i][W] ? (W+1)'(-seg_q.dir[i]) : seg_q.dir[i];
         offp_c[i] = (W+T_BITS+2)'(magd_c[i]) * (W+T_BITS+2)'(t_c);
      end
   end

   logic              v5_ff;
   logic [W:0]        off5_ff [3];
   logic [2:0]        dneg5_ff;
   logic [2:0][W-1:0] top5_ff, cen5_ff;
   logic [W-1:0]      rsum5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= tdiv_valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         off5_ff[i]  <= offp_c[i][T_BITS +: W+1];
         dneg5_ff[i] <= seg_q.dir[i][W];
      end
      top5_ff  <= seg_q.top;
      cen5_ff  <= seg_q.cen;
      rsum5_ff <= seg_q.rsum;
   end

   // stage 6: closest point and vector to the centre
   logic [W+1:0] topx_c [3];
   logic [W+1:0] cpt_c  [3];
   logic [W+1:0] vec_c  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         topx_c[i] = {{2{top5_ff[i][W-1]}}, top5_ff[i]};
         cpt_c[i]  = dneg5_ff[i] ? topx_c[i] - {1'b0, off5_ff[i]}
                                 : topx_c[i] + {1'b0, off5_ff[i]};
         vec_c[i]  = {{2{cen5_ff[i][W-1]}}, cen5_ff[i]} - cpt_c[i];
      end
   end

   logic                v6_ff;
   logic signed [W+1:0] vec6_ff [3];
   logic [W-1:0]        rsum6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         vec6_ff[i] <= vec_c[i];
      end
      rsum6_ff <= rsum5_ff;
   end

   // stage 7: squares
   logic               v7_ff;
   logic [2*W+3:0]     sq7_ff [3];
   logic [2:0][W+1:0]  vec7_ff;
   logic [W-1:0]       rsum7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq7_ff[i]  <= vec6_ff[i] * vec6_ff[i];
         vec7_ff[i] <= vec6_ff[i];
      end
      rsum7_ff <= rsum6_ff;
   end

   // stage 8: squared distance
   logic           v8_ff;
   logic [2*LW-1:0] l2_8_ff;
   dist_tag_type   dist8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else begin
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      l2_8_ff       <= (2*LW)'(sq7_ff[0]) + (2*LW)'(sq7_ff[1]) + (2*LW)'(sq7_ff[2]);
      dist8_ff.v    <= vec7_ff;
      dist8_ff.rsum <= rsum7_ff;
   end

   // distance = floor(sqrt(l2))
   logic          sqrt_valid;
   logic [LW-1:0] sqrt_root;
   logic [$bits(dist_tag_type)-1:0] sqrt_tag;
   dist_tag_type  dist_q;

   csc_sqrt #(
      .RW ($bits(l2_8_ff) / 2),
      .TW ($bits(dist_tag_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v8_ff),
      .in_rad    (l2_8_ff),
      .in_tag    (dist8_ff),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_tag   (sqrt_tag)
   );

   assign dist_q = sqrt_tag;

   // stage 9: hit test and overlap
   logic          v9_ff;
   logic          hit9_ff;
   logic [LW-1:0] len9_ff;
   logic [W-1:0]  ov9_ff;
   logic [W+1:0]  magv9_ff [3];
   logic [2:0]    vneg9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else begin
         v9_ff <= sqrt_valid;
      end
   end

   always_ff @(posedge clock) begin
      hit9_ff <= sqrt_root < LW'(dist_q.rsum);
      len9_ff <= sqrt_root;
      ov9_ff  <= dist_q.rsum - sqrt_root[W-1:0];
      for (int i = 0; i < 3; i++) begin
         magv9_ff[i] <= dist_q.v[i][W+1] ? (W+2)'(-dist_q.v[i]) : dist_q.v[i];
         vneg9_ff[i] <= dist_q.v[i][W+1];
      end
   end

   // stage 10: |v| * overlap
   logic           v10_ff;
   logic           hit10_ff;
   logic [LW-1:0]  len10_ff;
   logic [2*W+1:0] prd10_ff [3];
   logic [2:0]     vneg10_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else begin
         v10_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         prd10_ff[i] <= (2*W+2)'(magv9_ff[i]) * (2*W+2)'(ov9_ff);
      end
      hit10_ff  <= hit9_ff;
      len10_ff  <= len9_ff;
      vneg10_ff <= vneg9_ff;
   end

   // push = |v| * overlap / len per axis, flagged when the quotient overflows
   logic [2:0]    pdiv_valid;
   logic [W-1:0]  pdiv_quo [3];
   push_tag_type  ptag_q [3];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [W+1:0]  hi_c;
      logic          ovf_c;
      push_tag_type  tag_c;
      logic [$bits(push_tag_type)-1:0] tag_q;

      always_comb begin
         hi_c       = prd10_ff[i][2*W+1:W];
         ovf_c      = LW'(hi_c) >= len10_ff;
         tag_c.hit  = hit10_ff;
         tag_c.zlen = len10_ff == '0;
         tag_c.vneg = vneg10_ff[i];
         tag_c.ovf  = ovf_c;
      end

      csc_div #(
         .QW (W),
         .DW (LW),
         .TW ($bits(push_tag_type))
      ) u_pdiv (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v10_ff),
         .in_rem    (ovf_c ? '0 : LW'(hi_c)),
         .in_low    (prd10_ff[i][W-1:0]),
         .in_den    (len10_ff),
         .in_tag    (tag_c),
         .out_valid (pdiv_valid[i]),
         .out_quo   (pdiv_quo[i]),
         .out_tag   (tag_q)
      );

      assign ptag_q[i] = tag_q;
   end

   // output: saturate, apply the sign, zero on a miss or a zero length
   logic [W-1:0] lim_c  [3];
   logic [W-1:0] qm_c   [3];
   logic [W-1:0] push_c [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lim_c[i] = {ptag_q[i].vneg, {(W-1){~ptag_q[i].vneg}}};
         qm_c[i]  = (ptag_q[i].ovf || pdiv_quo[i] > lim_c[i]) ? lim_c[i] : pdiv_quo[i];
         if (!ptag_q[i].hit || ptag_q[i].zlen) begin
            push_c[i] = '0;
         end else begin
            push_c[i] = ptag_q[i].vneg ? W'(-qm_c[i]) : qm_c[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= &pdiv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit    <= ptag_q[0].hit;
      rsp_push_x <= push_c[0];
      rsp_push_y <= push_c[1];
      rsp_push_z <= push_c[2];
   end

endmodule

`default_nettype wire

FILE: src/csc_div.sv
//------------------------------------------------------------------------------
// csc_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csc_div #(
   parameter int QW = 32,
   parameter int DW = 64,
   parameter int TW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire logic [DW-1:0] in_rem,
   input  wire logic [QW-1:0] in_low,
   input  wire logic [DW-1:0] in_den,
   input  wire logic [TW-1:0] in_tag,
   output logic               out_valid,
   output logic [QW-1:0]      out_quo,
   output logic [TW-1:0]      out_tag
);

   logic [QW-1:0] vld_ff;
   logic [DW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [TW-1:0] tag_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          p_vld;
      logic [DW-1:0] p_rem;
      logic [DW-1:0] p_den;
      logic [QW-1:0] p_low;
      logic [QW-1:0] p_quo;
      logic [TW-1:0] p_tag;
      logic [DW:0]   trial;
      logic          take;

      if (k == 0) begin : g_first
         assign p_vld = in_valid;
         assign p_rem = in_rem;
         assign p_den = in_den;
         assign p_low = in_low;
         assign p_quo = '0;
         assign p_tag = in_tag;
      end else begin : g_next
         assign p_vld = vld_ff[k-1];
         assign p_rem = rem_ff[k-1];
         assign p_den = den_ff[k-1];
         assign p_low = low_ff[k-1];
         assign p_quo = quo_ff[k-1];
         assign p_tag = tag_ff[k-1];
      end

      // shift in the next dividend bit and try the subtract
      always_comb begin
         trial = {p_rem, p_low[QW-1]};
         take  = trial >= {1'b0, p_den};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= take ? DW'(trial - {1'b0, p_den}) : DW'(trial);
         den_ff[k] <= p_den;
         low_ff[k] <= p_low << 1;
         quo_ff[k] <= {p_quo[QW-2:0], take};
         tag_ff[k] <= p_tag;
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

endmodule

`default_nettype wire

FILE: src/csc_sqrt.sv
//------------------------------------------------------------------------------
// csc_sqrt
// Pipelined integer square root, one result bit per stage, with a side tag.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csc_sqrt #(
   parameter int RW = 32,
   parameter int TW = 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire logic [2*RW-1:0] in_rad,
   input  wire logic [TW-1:0]   in_tag,
   output logic                 out_valid,
   output logic [RW-1:0]        out_root,
   output logic [TW-1:0]        out_tag
);

   logic [RW-1:0]   vld_ff;
   logic [2*RW-1:0] rem_ff [RW];
   logic [RW-1:0]   res_ff [RW];
   logic [TW-1:0]   tag_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      localparam int B = RW - 1 - k;
      logic            p_vld;
      logic [2*RW-1:0] p_rem;
      logic [RW-1:0]   p_res;
      logic [TW-1:0]   p_tag;
      logic [2*RW:0]   trial;
      logic            take;

      if (k == 0) begin : g_first
         assign p_vld = in_valid;
         assign p_rem = in_rad;
         assign p_res = '0;
         assign p_tag = in_tag;
      end else begin : g_next
         assign p_vld = vld_ff[k-1];
         assign p_rem = rem_ff[k-1];
         assign p_res = res_ff[k-1];
         assign p_tag = tag_ff[k-1];
      end

      // (res + 2^B)^2 - res^2 against what is left of the radicand
      always_comb begin
         trial = ((2*RW+1)'(p_res) << (B + 1)) + ((2*RW+1)'(1) << (2 * B));
         take  = {1'b0, p_rem} >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= take ? (2*RW)'({1'b0, p_rem} - trial) : p_rem;
         res_ff[k] <= take ? (p_res | (RW'(1) << B)) : p_res;
         tag_ff[k] <= p_tag;
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = res_ff[RW-1];
   assign out_tag   = tag_ff[RW-1];

endmodule

`default_nettype wire

FILE: src/csc_check.sv
//------------------------------------------------------------------------------
// csc_check
// Port-level checks for the collision pipeline, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csc_check #(
   parameter int COORD_WIDTH = 32
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_hit,
   input wire logic [COORD_WIDTH-1:0] rsp_push_x,
   input wire logic [COORD_WIDTH-1:0] rsp_push_y,
   input wire logic [COORD_WIDTH-1:0] rsp_push_z
);

   import csc_pkg::*;

   localparam int LAT = csc_latency(COORD_WIDTH);

   // every transfer yields its result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result missing after transfer");

   // no result without a transfer at the matching cycle
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without transfer");

   // a miss carries a zero push
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |->
         (rsp_push_x == '0 && rsp_push_y == '0 && rsp_push_z == '0))
      else $error("non-zero push on a miss");

   // busy only while reset is held
   a_busy: assert property (@(posedge clock)
      !reset |-> !busy)
      else $error("busy outside reset");

endmodule

bind capsule_sphere_collision csc_check #(
   .COORD_WIDTH (COORD_WIDTH)
) u_csc_check (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_hit    (rsp_hit),
   .rsp_push_x (rsp_push_x),
   .rsp_push_y (rsp_push_y),
   .rsp_push_z (rsp_push_z)
);

`default_nettype wire

FILE: test/tb.sv
//------------------------------------------------------------------------------
// tb
// Self-checking bench for capsule_sphere_collision: directed and random
// queries, each compared against a wide-integer collision predictor.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import csc_pkg::*;

   localparam int CW       = 32;
   localparam int LATENCY  = 46 + 2 * CW;
   localparam int WD_LIMIT = 4000;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic [CW-2:0]        radius_type;

   typedef struct packed {
      coord_type  top_x, top_y, top_z, bot_x, bot_y, bot_z;
      radius_type cap_r;
      coord_type  cen_x, cen_y, cen_z;
      radius_type sph_r;
   } query_type;

   typedef struct packed {
      logic      hit;
      coord_type push_x, push_y, push_z;
   } contact_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type  req_top_x = '0, req_top_y = '0, req_top_z = '0;
   coord_type  req_bottom_x = '0, req_bottom_y = '0, req_bottom_z = '0;
   radius_type req_capsule_radius = '0, req_sphere_radius = '0;
   coord_type  req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic    rsp_valid, rsp_hit;
   logic [CW-1:0] rsp_push_x, rsp_push_y, rsp_push_z;

   contact_type expected_contacts[$];
   int errors    = 0;
   int n_sent    = 0;
   int n_checked = 0;
   int n_hits    = 0;
   int idle_pct  = 0;
   int quiet     = 0;

   capsule_sphere_collision #(.COORD_WIDTH(CW)) u_dut (
      .clock, .reset, .start, .busy,
      .req_top_x, .req_top_y, .req_top_z,
      .req_bottom_x, .req_bottom_y, .req_bottom_z,
      .req_capsule_radius,
      .req_center_x, .req_center_y, .req_center_z,
      .req_sphere_radius,
      .rsp_valid, .rsp_hit, .rsp_push_x, .rsp_push_y, .rsp_push_z
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // integer square root, floor
   function automatic logic [63:0] isqrt128(input logic [127:0] x);
      logic [63:0]  r;
      logic [63:0]  c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (128'(c) * 128'(c) <= x) r = c;
      end
      return r;
   endfunction

   // predict the contact for one query
   function automatic contact_type predict_contact(input query_type q);
      contact_type res;
      logic signed [63:0]  tp[3], bt[3], cn[3], d[3], cl[3], v[3];
      logic signed [127:0] num, den;
      logic [127:0] l2, nu, de, p, qv;
      logic [63:0]  t, len, rsum, ov, lim, mg;
      mode_type     mode;
      tp = '{q.top_x, q.top_y, q.top_z};
      bt = '{q.bot_x, q.bot_y, q.bot_z};
      cn = '{q.cen_x, q.cen_y, q.cen_z};
      num = 0;
      den = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = bt[i] - tp[i];
         num += 128'(cn[i] - tp[i]) * 128'(d[i]);
         den += 128'(d[i]) * 128'(d[i]);
      end
      rsum = 64'(q.cap_r) + 64'(q.sph_r);
      if (den == 0 || num <= 0) mode = MODE_TOP;
      else if (num >= den) mode = MODE_BOTTOM;
      else mode = MODE_MID;
      for (int i = 0; i < 3; i++) begin
         case (mode)
            MODE_TOP: begin
               cl[i] = tp[i];
            end
            MODE_BOTTOM: begin
               cl[i] = bt[i];
            end
            default: begin
               nu = num;
               de = den;
               while (de >= (128'd1 << NORM_BITS)) begin
                  nu = nu >> 1;
                  de = de >> 1;
               end
               t = 64'((nu << T_BITS) / de);
               mg = d[i] < 0 ? -d[i] : d[i];
               p = 128'(mg) * 128'(t);
               cl[i] = d[i] < 0 ? tp[i] - 64'(p >> 32) : tp[i] + 64'(p >> 32);
            end
         endcase
      end
      l2 = 0;
      for (int i = 0; i < 3; i++) begin
         v[i] = cn[i] - cl[i];
         l2 += 128'(v[i]) * 128'(v[i]);
      end
      len = isqrt128(l2);
      res.hit = len < rsum;
      res.push_x = '0;
      res.push_y = '0;
      res.push_z = '0;
      if (res.hit && len > 0) begin
         ov = rsum - len;
         for (int i = 0; i < 3; i++) begin
            mg  = v[i] < 0 ? -v[i] : v[i];
            lim = v[i] < 0 ? (64'd1 << (CW - 1)) : (64'd1 << (CW - 1)) - 1;
            qv  = (128'(mg) * 128'(ov)) / 128'(len);
            if (qv > 128'(lim)) qv = 128'(lim);
            mg = v[i] < 0 ? -qv[63:0] : qv[63:0];
            if (i == 0) res.push_x = mg[CW-1:0];
            else if (i == 1) res.push_y = mg[CW-1:0];
            else res.push_z = mg[CW-1:0];
         end
      end
      return res;
   endfunction

   // send one query, with random idle cycles beforehand
   task automatic send_query(input query_type q);
      while ($urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start              <= 1'b1;
      req_top_x          <= q.top_x;
      req_top_y          <= q.top_y;
      req_top_z          <= q.top_z;
      req_bottom_x       <= q.bot_x;
      req_bottom_y       <= q.bot_y;
      req_bottom_z       <= q.bot_z;
      req_capsule_radius <= q.cap_r;
      req_center_x       <= q.cen_x;
      req_center_y       <= q.cen_y;
      req_center_z       <= q.cen_z;
      req_sphere_radius  <= q.sph_r;
      do @(posedge clock); while (busy);
      expected_contacts.insert(expected_contacts.size(), predict_contact(q));
      n_sent++;
   endtask

   task automatic end_burst();
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic coord_type rnd_coord(input int span);
      case ($urandom_range(3, 0))
         0: return coord_type'($urandom);
         default: return coord_type'($signed($urandom_range(2 * span, 0)) - span);
      endcase
   endfunction

   function automatic radius_type rnd_radius(input int span);
      return $urandom_range(3, 0) == 0 ? radius_type'($urandom)
                                       : radius_type'($urandom_range(span, 0));
   endfunction

   // mostly near-contact geometry so hits and misses both occur
   function automatic query_type rnd_query();
      query_type q;
      int span;
      span = 1 << $urandom_range(30, 4);
      q.top_x = rnd_coord(span); q.top_y = rnd_coord(span); q.top_z = rnd_coord(span);
      if ($urandom_range(9, 0) == 0) begin
         q.bot_x = q.top_x; q.bot_y = q.top_y; q.bot_z = q.top_z;
      end else begin
         q.bot_x = rnd_coord(span); q.bot_y = rnd_coord(span); q.bot_z = rnd_coord(span);
      end
      q.cen_x = rnd_coord(span); q.cen_y = rnd_coord(span); q.cen_z = rnd_coord(span);
      q.cap_r = rnd_radius(span);
      q.sph_r = rnd_radius(span);
      return q;
   endfunction

   task automatic wait_drained();
      while (expected_contacts.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic test_directed();
      query_type q;
      coord_type mx, mn;
      mx = {1'b0, {(CW-1){1'b1}}};
      mn = {1'b1, {(CW-1){1'b0}}};
      idle_pct = 0;
      // zero-length segment, zero direction
      q = '0; send_query(q);
      q.cap_r = 1; send_query(q);
      // zero-length segment away from origin
      q = '0; q.top_x = 100; q.bot_x = 100; q.cen_x = 103; q.cap_r = 2; q.sph_r = 2;
      send_query(q);
      // clamp to top, bottom and interior along x
      q = '0; q.bot_x = 1000; q.cen_x = -50; q.cen_y = 5; q.cap_r = 40; q.sph_r = 20;
      send_query(q);
      q.cen_x = 1050; send_query(q);
      q.cen_x = 500; q.cen_y = 30; send_query(q);
      q.cen_y = -30; q.cen_z = 7; send_query(q);
      // centre on the segment: zero direction with a hit
      q.cen_y = 0; q.cen_z = 0; send_query(q);
      // extreme coordinates and radii, push saturation
      q = '{mn, mn, mn, mx, mx, mx, '1, mx, mn, mx, '1}; send_query(q);
      q = '{mx, mx, mx, mn, mn, mn, '1, mn, mn, mn, '1}; send_query(q);
      q = '{mx, mn, mx, mx, mn, mx, '1, mn, mx, mn, '1}; send_query(q);
      q = '{mn, mn, mn, mn, mn, mn, '1, mn + 1, mn, mn, '1}; send_query(q);
      q = '{mx, mx, mx, mx, mx, mx, '0, mx, mx, mx, '0}; send_query(q);
      q = '{'1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1}; send_query(q);
      // diagonal interior projection
      q = '{-300, 200, 100, 700, -900, 400, 5000, 50, 60, -70, 3000}; send_query(q);
      end_burst();
   endtask

   task automatic test_random(input int count, input int pct);
      idle_pct = pct;
      repeat (count) send_query(rnd_query());
      end_burst();
   endtask

   task automatic test_pause_until_drained();
      test_random(20, 0);
      wait_drained();
      test_random(20, 0);
   endtask

   // compare each result strobe with the oldest prediction
   always @(posedge clock) begin
      contact_type exp_c;
      if (!reset && rsp_valid) begin
         if (expected_contacts.size() == 0) begin
            $error("unexpected result: hit=%0b", rsp_hit);
            errors++;
         end else begin
            exp_c = expected_contacts.pop_front();
            if (rsp_hit !== exp_c.hit) begin
               $error("hit expected %0b actual %0b", exp_c.hit, rsp_hit);
               errors++;
            end
            if (rsp_push_x !== exp_c.push_x) begin
               $error("push_x expected %0d actual %0d", exp_c.push_x, $signed(rsp_push_x));
               errors++;
            end
            if (rsp_push_y !== exp_c.push_y) begin
               $error("push_y expected %0d actual %0d", exp_c.push_y, $signed(rsp_push_y));
               errors++;
            end
            if (rsp_push_z !== exp_c.push_z) begin
               $error("push_z expected %0d actual %0d", exp_c.push_z, $signed(rsp_push_z));
               errors++;
            end
            n_checked++;
            if (rsp_hit) n_hits++;
         end
      end
   end

   // watchdog: count cycles with no transfer in either direction
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WD_LIMIT) begin
         $display("capsule_sphere_collision test failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(500, 0);
      test_random(300, 87);
      test_pause_until_drained();
      test_random(300, 12);
      test_random(400, 0);
      wait_drained();
      $display("Covered %0d queries (%0d hits), %0d results checked, idle 0/12/87 percent.",
               n_sent, n_hits, n_checked);
      if (errors == 0 && expected_contacts.size() == 0)
         $display("capsule_sphere_collision test passed");
      else
         $display("capsule_sphere_collision test failed");
      $finish;
   end

endmodule
